/* hdl/obc_pkg.sv */
package obc_pkg;

   localparam int FRACTION_BITS     = 8;
   localparam int CORDIC_ITERATIONS = 16;
   localparam int ITER_W            = $clog2(CORDIC_ITERATIONS + 1);

   localparam int FULL_TURN   = 360 << FRACTION_BITS;
   localparam int MAX_POLAR   = (90 << FRACTION_BITS) - 1;
   localparam int POLAR_RESET = 45 << FRACTION_BITS;
   localparam int POLAR_SPAN  = 2 * MAX_POLAR;

   // A full turn is 45 << TURN_LOW_BITS, so the azimuth wrap keeps the low bits
   // and reduces the upper part by 45 with a reciprocal multiply.
   localparam int TURN_LOW_BITS = FRACTION_BITS + 3;
   localparam int TURN_ODD      = 45;
   localparam int TURN_RECIP    = 5965233;
   localparam int TURN_SHIFT    = 28;

   localparam int CORDIC_TURN = 360 << 16;
   localparam int CORDIC_GAIN = 652032874;

   localparam int DIV_W = 36;
   localparam int DSR_W = 17;

   typedef enum logic [1:0] {
      KIND_PRESS = 2'd0,
      KIND_MOVE  = 2'd1,
      KIND_ZOOM  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      REG_WIDTH    = 3'd0,
      REG_HEIGHT   = 3'd1,
      REG_CENTER_X = 3'd2,
      REG_CENTER_Y = 3'd3,
      REG_CENTER_Z = 3'd4,
      REG_MIN_RAD  = 3'd5,
      REG_START_RAD = 3'd6
   } reg_index_type;

   // Start and done strobes of an iterative unit.
   typedef struct packed {
      logic start;
   } unit_cmd_type;

   typedef struct packed {
      logic done;
   } unit_sts_type;

   // atan(2^-i) in degrees, Q.16.
   function automatic logic [22:0] atan_deg(input logic [4:0] i);
      logic [22:0] v;
      begin
         case (i)
            5'd0:  v = 23'd2949120;
            5'd1:  v = 23'd1740967;
            5'd2:  v = 23'd919879;
            5'd3:  v = 23'd466945;
            5'd4:  v = 23'd234379;
            5'd5:  v = 23'd117304;
            5'd6:  v = 23'd58666;
            5'd7:  v = 23'd29335;
            5'd8:  v = 23'd14668;
            5'd9:  v = 23'd7334;
            5'd10: v = 23'd3667;
            5'd11: v = 23'd1833;
            5'd12: v = 23'd917;
            5'd13: v = 23'd458;
            5'd14: v = 23'd229;
            5'd15: v = 23'd115;
            5'd16: v = 23'd57;
            5'd17: v = 23'd29;
            5'd18: v = 23'd14;
            5'd19: v = 23'd7;
            5'd20: v = 23'd4;
            5'd21: v = 23'd2;
            5'd22: v = 23'd1;
            default: v = 23'd0;
         endcase
         return v;
      end
   endfunction

endpackage

/* hdl/obc_div.sv */
module obc_div (
   input  logic                        clock,
   input  logic                        reset,
   input  obc_pkg::unit_cmd_type       cmd,
   input  logic [obc_pkg::DIV_W-1:0]   dividend,
   input  logic [obc_pkg::DSR_W-1:0]   divisor,
   output obc_pkg::unit_sts_type       sts,
   output logic [obc_pkg::DIV_W-1:0]   quotient
);
   import obc_pkg::*;

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DSR_W-1:0] rem_ff, rem_in, dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [DSR_W:0]   trial;

   // One quotient bit per cycle, restoring form.
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[DIV_W-1]} - {1'b0, dsr_ff};
      if (cmd.start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CNT_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DSR_W]) begin
            rem_in = trial[DSR_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DSR_W-2:0], quo_ff[DIV_W-1]};
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign sts.done  = done_ff;
   assign quotient  = quo_ff;

endmodule

/* hdl/obc_cordic.sv */
module obc_cordic (
   input  logic                  clock,
   input  logic                  reset,
   input  obc_pkg::unit_cmd_type cmd,
   input  logic signed [17:0]    angle,
   output obc_pkg::unit_sts_type sts,
   output logic signed [31:0]    sin_q30,
   output logic signed [31:0]    cos_q30
);
   import obc_pkg::*;

   logic signed [31:0] x_ff, x_in, y_ff, y_in;
   logic signed [26:0] a_ff, a_in, a0;
   logic [ITER_W-1:0]  i_ff, i_in;
   logic               neg_ff, neg_in, busy_ff, busy_in, done_ff, done_in;
   logic signed [26:0] step;

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      a_in    = a_ff;
      i_in    = i_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      a0      = 27'(angle) <<< (16 - FRACTION_BITS);
      step    = 27'($signed({1'b0, atan_deg(5'(i_ff))}));
      if (cmd.start) begin
         // Fold the angle into the right half plane first.
         neg_in = 1'b0;
         if (a0 > 27'(CORDIC_TURN / 2)) a0 = a0 - 27'(CORDIC_TURN);
         if (a0 > 27'(CORDIC_TURN / 4)) begin
            a0     = a0 - 27'(CORDIC_TURN / 2);
            neg_in = 1'b1;
         end else if (a0 < -27'(CORDIC_TURN / 4)) begin
            a0     = a0 + 27'(CORDIC_TURN / 2);
            neg_in = 1'b1;
         end
         a_in    = a0;
         x_in    = 32'(CORDIC_GAIN);
         y_in    = '0;
         i_in    = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (a_ff >= 0) begin
            x_in = x_ff - (y_ff >>> i_ff);
            y_in = y_ff + (x_ff >>> i_ff);
            a_in = a_ff - step;
         end else begin
            x_in = x_ff + (y_ff >>> i_ff);
            y_in = y_ff - (x_ff >>> i_ff);
            a_in = a_ff + step;
         end
         i_in = i_ff + 1'b1;
         if (i_ff == ITER_W'(CORDIC_ITERATIONS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         i_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         i_ff    <= i_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      a_ff   <= a_in;
      neg_ff <= neg_in;
   end

   assign sts.done = done_ff;
   assign sin_q30  = neg_ff ? -y_ff : y_ff;
   assign cos_q30  = neg_ff ? -x_ff : x_ff;

endmodule

/* hdl/orbit_camera_eye_update.sv */
// Orbit camera eye update.
// The req channel takes one pointer event per item: tuser holds the event kind
// (press, move, zoom, none), tdata the pointer position and the zoom step.
// The csr channel writes the window size, orbit center, minimum and start
// radius; it is always ready. It must be written by the user only while no
// event is in flight; the block itself does not enforce this. Each event
// returns one item on the rsp channel: the eye position and the current
// azimuth, polar angle and radius. An event is handled by a sequencer around
// three shared units: a radix-2 divider, a CORDIC (16 iterations) used for
// the polar and then the azimuth angle, and one 34x32 multiplier used four
// times. A move event adds two divider passes and an azimuth wrap before the
// CORDIC; a press, zoom or idle event goes straight to the CORDIC. req_tready
// is low while an event is worked on, so the next event can be accepted once
// the result is in the output register.
// The result sits in an output register; the next event is accepted while
// it waits, and a finished event waits while rsp_tready is low.
// Synchronous reset restores the register defaults (1024 x 768 window,
// center and radius zero, polar 45 degrees) and drops rsp_tvalid.
module orbit_camera_eye_update (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [55:0]  req_tdata,  // pointer_x, pointer_y, zoom_step
   input  logic [1:0]   req_tuser,  // kind
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // eye_x, eye_y, eye_z, azimuth_out, polar_out, radius_out
   output logic [159:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);
   import obc_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_EXEC, S_DIVA, S_MODA, S_WRAP, S_DIVP, S_CORP, S_CORA,
      S_M1, S_R1, S_M2, S_R2, S_M3, S_R3, S_M4, S_R4, S_OUT
   } state_type;

   state_type state_ff, state_in;

   logic [15:0]        ww_ff, ww_in, wh_ff, wh_in;
   logic signed [31:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic [30:0]        minr_ff, minr_in, rad_ff, rad_in;
   logic signed [15:0] dsx_ff, dsx_in, dsy_ff, dsy_in, px_ff, px_in, py_ff, py_in;
   logic signed [23:0] zs_ff, zs_in;
   kind_type           kind_ff, kind_in;
   logic [16:0]        saz_ff, saz_in, az_ff, az_in;
   logic signed [15:0] spo_ff, spo_in, po_ff, po_in;
   logic               neg_ff, neg_in;
   logic signed [31:0] sp_ff, sp_in, cp_ff, cp_in, sa_ff, sa_in, ca_ff, ca_in;
   logic signed [65:0] prod_ff, prod_in;
   logic signed [33:0] rc_ff, rc_in;
   logic signed [31:0] ex_ff, ex_in, ey_ff, ey_in, ez_ff, ez_in;
   logic [159:0]       out_ff, out_in;
   logic               ov_ff, ov_in;
   logic [32:0]        mag_ff, mag_in;
   logic [16:0]        modq_ff, modq_in;

   unit_cmd_type       div_cmd, cor_cmd;
   unit_sts_type       div_sts, cor_sts;
   logic [DIV_W-1:0]   div_dvd, div_quo;
   logic [DSR_W-1:0]   div_dsr;
   logic signed [17:0] cor_ang;
   logic signed [31:0] cor_sin, cor_cos;

   logic signed [33:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [16:0] dpix;
   logic signed [34:0] scaled;
   logic signed [37:0] qsum;
   logic signed [32:0] zsum;
   logic signed [35:0] term;
   logic signed [36:0] esum;
   logic signed [31:0] ecenter;
   logic [16:0]        wrapped;
   logic [21:0]        mhi;
   logic [44:0]        mprod;
   logic [5:0]         modr;
   logic [16:0]        turn_rem;

   function automatic logic signed [35:0] round_q30(input logic signed [65:0] p);
      logic signed [66:0] t;
      begin
         t = 67'(p) + 67'(1 << 29);
         return t[65:30];
      end
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
      logic signed [31:0] r;
      begin
         if (v > 37'sd2147483647) r = 32'sh7FFFFFFF;
         else if (v < -37'sd2147483648) r = 32'sh80000000;
         else r = v[31:0];
         return r;
      end
   endfunction

   obc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .cmd       (div_cmd),
      .dividend  (div_dvd),
      .divisor   (div_dsr),
      .sts       (div_sts),
      .quotient  (div_quo)
   );

   obc_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cor_cmd),
      .angle   (cor_ang),
      .sts     (cor_sts),
      .sin_q30 (cor_sin),
      .cos_q30 (cor_cos)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = out_ff;

   always_comb begin
      unique case (state_ff)
         S_M1:    begin mul_a = 34'($signed({1'b0, rad_ff})); mul_b = cp_ff; end
         S_M2:    begin mul_a = rc_ff; mul_b = ca_ff; end
         S_M3:    begin mul_a = rc_ff; mul_b = sa_ff; end
         default: begin mul_a = 34'($signed({1'b0, rad_ff})); mul_b = sp_ff; end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      ww_in = ww_ff;  wh_in = wh_ff;
      cx_in = cx_ff;  cy_in = cy_ff;  cz_in = cz_ff;
      minr_in = minr_ff;  rad_in = rad_ff;
      dsx_in = dsx_ff;  dsy_in = dsy_ff;
      px_in = px_ff;  py_in = py_ff;  zs_in = zs_ff;  kind_in = kind_ff;
      saz_in = saz_ff;  az_in = az_ff;  spo_in = spo_ff;  po_in = po_ff;
      neg_in = neg_ff;
      sp_in = sp_ff;  cp_in = cp_ff;  sa_in = sa_ff;  ca_in = ca_ff;
      prod_in = prod_ff;  rc_in = rc_ff;
      ex_in = ex_ff;  ey_in = ey_ff;  ez_in = ez_ff;
      mag_in = mag_ff;  modq_in = modq_ff;
      out_in = out_ff;
      ov_in = ov_ff && !rsp_tready;
      div_cmd.start = 1'b0;
      cor_cmd.start = 1'b0;
      div_dvd = '0;
      div_dsr = DSR_W'(1);
      dpix    = '0;
      scaled  = '0;
      qsum    = '0;
      zsum    = '0;
      wrapped = '0;
      mhi     = mag_ff[32:TURN_LOW_BITS];
      mprod   = '0;
      modr    = '0;
      turn_rem = '0;
      cor_ang = 18'($signed(po_ff));
      term    = round_q30(prod_ff);
      ecenter = cx_ff;
      unique case (state_ff)
         S_M2, S_R2: ecenter = cx_ff;
         S_M3, S_R3: ecenter = cy_ff;
         default:    ecenter = cz_ff;
      endcase
      esum = 37'(ecenter) + 37'(term);

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_WIDTH:     ww_in = csr_data[15:0];
            REG_HEIGHT:    wh_in = csr_data[15:0];
            REG_CENTER_X:  cx_in = csr_data;
            REG_CENTER_Y:  cy_in = csr_data;
            REG_CENTER_Z:  cz_in = csr_data;
            REG_MIN_RAD:   minr_in = csr_data[30:0];
            REG_START_RAD: rad_in = csr_data[30:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               px_in    = req_tdata[15:0];
               py_in    = req_tdata[31:16];
               zs_in    = req_tdata[55:32];
               kind_in  = kind_type'(req_tuser);
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (kind_ff)
               KIND_PRESS: begin
                  dsx_in = px_ff;
                  dsy_in = py_ff;
                  saz_in = az_ff;
                  spo_in = po_ff;
                  cor_cmd.start = 1'b1;
                  state_in = S_CORP;
               end
               KIND_MOVE: begin
                  dpix   = 17'(px_ff) - 17'(dsx_ff);
                  scaled = 35'(dpix) * 35'(FULL_TURN);
                  neg_in = scaled[34];
                  div_dvd = DIV_W'(scaled[34] ? -scaled : scaled);
                  div_dsr = (ww_ff == '0) ? DSR_W'(1) : DSR_W'(ww_ff);
                  div_cmd.start = 1'b1;
                  state_in = S_DIVA;
               end
               KIND_ZOOM: begin
                  zsum = 33'($signed({1'b0, rad_ff})) + 33'(zs_ff);
                  if (zsum < 33'($signed({1'b0, minr_ff}))) rad_in = minr_ff;
                  else if (zsum > 33'sh7FFFFFFF) rad_in = 31'h7FFFFFFF;
                  else rad_in = zsum[30:0];
                  cor_cmd.start = 1'b1;
                  state_in = S_CORP;
               end
               default: begin
                  cor_cmd.start = 1'b1;
                  state_in = S_CORP;
               end
            endcase
         end
         S_DIVA: begin
            if (div_sts.done) begin
               qsum = 38'($signed({1'b0, saz_ff}))
                    + (neg_ff ? -38'($signed({1'b0, div_quo}))
                              : 38'($signed({1'b0, div_quo})));
               neg_in   = qsum[37];
               mag_in   = 33'(qsum[37] ? -qsum : qsum);
               state_in = S_MODA;
            end
         end
         S_MODA: begin
            // Quotient of the upper bits by 45, exact for every 22-bit value.
            mprod    = 45'(mhi) * 45'(TURN_RECIP);
            modq_in  = mprod[TURN_SHIFT+16:TURN_SHIFT];
            state_in = S_WRAP;
         end
         S_WRAP: begin
            modr     = 6'(23'(mhi) - 23'(modq_ff) * 23'(TURN_ODD));
            turn_rem = {modr, mag_ff[TURN_LOW_BITS-1:0]};
            // A negative sum wraps up into the turn.
            wrapped = (neg_ff && turn_rem != '0) ? 17'(FULL_TURN) - turn_rem : turn_rem;
            az_in   = wrapped;
            dpix    = 17'(py_ff) - 17'(dsy_ff);
            scaled  = 35'(dpix) * 35'(POLAR_SPAN);
            neg_in  = scaled[34];
            div_dvd = DIV_W'(scaled[34] ? -scaled : scaled);
            div_dsr = (wh_ff == '0) ? DSR_W'(1) : DSR_W'(wh_ff);
            div_cmd.start = 1'b1;
            state_in = S_DIVP;
         end
         S_DIVP: begin
            if (div_sts.done) begin
               qsum = 38'(spo_ff)
                    + (neg_ff ? -38'($signed({1'b0, div_quo}))
                              : 38'($signed({1'b0, div_quo})));
               if (qsum > 38'(MAX_POLAR)) po_in = 16'(MAX_POLAR);
               else if (qsum < -38'(MAX_POLAR)) po_in = -16'(MAX_POLAR);
               else po_in = qsum[15:0];
               cor_ang = 18'(po_in);
               cor_cmd.start = 1'b1;
               state_in = S_CORP;
            end
         end
         S_CORP: begin
            if (cor_sts.done) begin
               sp_in = cor_sin;
               cp_in = cor_cos;
               cor_ang = 18'($signed({1'b0, az_ff}));
               cor_cmd.start = 1'b1;
               state_in = S_CORA;
            end
         end
         S_CORA: begin
            if (cor_sts.done) begin
               sa_in = cor_sin;
               ca_in = cor_cos;
               state_in = S_M1;
            end
         end
         S_M1: begin prod_in = mul_a * mul_b; state_in = S_R1; end
         S_R1: begin rc_in = term[33:0]; state_in = S_M2; end
         S_M2: begin prod_in = mul_a * mul_b; state_in = S_R2; end
         S_R2: begin ex_in = sat32(esum); state_in = S_M3; end
         S_M3: begin prod_in = mul_a * mul_b; state_in = S_R3; end
         S_R3: begin ey_in = sat32(esum); state_in = S_M4; end
         S_M4: begin prod_in = mul_a * mul_b; state_in = S_R4; end
         S_R4: begin ez_in = sat32(esum); state_in = S_OUT; end
         S_OUT: begin
            if (!ov_ff || rsp_tready) begin
               out_in = {rad_ff, po_ff, az_ff, ez_ff, ey_ff, ex_ff};
               ov_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ov_ff    <= 1'b0;
         ww_ff    <= 16'd1024;
         wh_ff    <= 16'd768;
         cx_ff    <= '0;
         cy_ff    <= '0;
         cz_ff    <= '0;
         minr_ff  <= '0;
         rad_ff   <= '0;
         dsx_ff   <= '0;
         dsy_ff   <= '0;
         saz_ff   <= '0;
         az_ff    <= '0;
         spo_ff   <= 16'(POLAR_RESET);
         po_ff    <= 16'(POLAR_RESET);
      end else begin
         state_ff <= state_in;
         ov_ff    <= ov_in;
         ww_ff    <= ww_in;
         wh_ff    <= wh_in;
         cx_ff    <= cx_in;
         cy_ff    <= cy_in;
         cz_ff    <= cz_in;
         minr_ff  <= minr_in;
         rad_ff   <= rad_in;
         dsx_ff   <= dsx_in;
         dsy_ff   <= dsy_in;
         saz_ff   <= saz_in;
         az_ff    <= az_in;
         spo_ff   <= spo_in;
         po_ff    <= po_in;
      end
      px_ff   <= px_in;
      py_ff   <= py_in;
      zs_ff   <= zs_in;
      kind_ff <= kind_in;
      neg_ff  <= neg_in;
      sp_ff   <= sp_in;
      cp_ff   <= cp_in;
      sa_ff   <= sa_in;
      ca_ff   <= ca_in;
      prod_ff <= prod_in;
      rc_ff   <= rc_in;
      ex_ff   <= ex_in;
      ey_ff   <= ey_in;
      ez_ff   <= ez_in;
      mag_ff  <= mag_in;
      modq_ff <= modq_in;
      out_ff  <= out_in;
   end

endmodule

/* hdl/obc_checker.sv */
module obc_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [159:0] rsp_tdata
);

   // Reset drops any pending result.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // An accepted item keeps the block busy for at least the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("block ready right after accept");

   a_azimuth_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[112:96] < 17'd92160)
      else $error("azimuth out of range");

   a_polar_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[128:113]) <= 16'sd23039)
                  && ($signed(rsp_tdata[128:113]) >= -16'sd23039))
      else $error("polar out of range");

endmodule

bind orbit_camera_eye_update obc_checker u_obc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
